// ----- design/mc_pkg.sv -----
// Package for the mask centroid block: field widths, register indexes,
// reset values and the types shared between the front end, queue and divider.
// No dependencies.
package mc_pkg;

    localparam int PIX_W  = 8;   // red value and match value
    localparam int POS_W  = 11;  // column, row, size registers and centroid fields
    localparam int SUM_W  = 31;  // column and row sums
    localparam int AREA_W = 21;  // matching pixel count

    localparam int DEFAULT_MAX_WIDTH  = 1024;
    localparam int DEFAULT_MAX_HEIGHT = 1024;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = POS_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_MATCH_VALUE  = 2'd2
    } cfg_index_t;

    localparam logic [POS_W-1:0] RESET_FRAME_WIDTH  = 11'd10;
    localparam logic [POS_W-1:0] RESET_FRAME_HEIGHT = 11'd14;
    localparam logic [PIX_W-1:0] RESET_MATCH_VALUE  = 8'd254;

    // Queue between front end and divider; the depth must be a power of two.
    localparam int FIFO_DEPTH = 2;

    // One quotient bit per divider step.
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [SUM_W-1:0]  column_sum;
        logic [SUM_W-1:0]  row_sum;
        logic [AREA_W-1:0] match_count;
    } frame_sums_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_HOLD
    } div_state_t;

endpackage

// ----- design/mc_if.sv -----
// Channel interfaces of the mask centroid block: pixel input, result output
// and configuration writes. Depends on mc_pkg.

interface mc_pixel_if;
    import mc_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_value;

    modport source (output valid, output red_value, input ready);
    modport sink   (input valid, input red_value, output ready);
endinterface

interface mc_result_if;
    import mc_pkg::*;
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  centroid_x;
    logic [POS_W-1:0]  centroid_y;
    logic [AREA_W-1:0] object_area;
    logic              empty_frame;

    modport source (output valid, output centroid_x, output centroid_y,
                    output object_area, output empty_frame, input ready);
    modport sink   (input valid, input centroid_x, input centroid_y,
                    input object_area, input empty_frame, output ready);
endinterface

interface mc_cfg_if;
    import mc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/mc_front.sv -----
// Front end of the mask centroid block: configuration registers, pixel
// position tracking and per-frame accumulation. Depends on mc_pkg and mc_if.
module mc_front #(
    parameter int MAX_WIDTH  = mc_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = mc_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                clk,
    input  logic                rst_n,
    mc_cfg_if.sink              cfg,
    mc_pixel_if.sink            pixel,
    output mc_pkg::frame_sums_t sums,
    output logic                sums_valid,
    input  logic                sums_ready
);
    import mc_pkg::*;

    logic [POS_W-1:0]  frame_width_reg;
    logic [POS_W-1:0]  frame_height_reg;
    logic [PIX_W-1:0]  match_value_reg;
    logic [POS_W-1:0]  column_reg, column_next;
    logic [POS_W-1:0]  row_reg, row_next;
    logic [SUM_W-1:0]  column_sum_reg, column_sum_next;
    logic [SUM_W-1:0]  row_sum_reg, row_sum_next;
    logic [AREA_W-1:0] count_reg, count_next;
    logic [POS_W-1:0]  eff_width;
    logic [POS_W-1:0]  eff_height;
    logic              hit;
    logic              frame_end;
    logic              accept;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RESET_FRAME_WIDTH;
            frame_height_reg <= RESET_FRAME_HEIGHT;
            match_value_reg  <= RESET_MATCH_VALUE;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg.data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg.data;
                CFG_MATCH_VALUE:  match_value_reg  <= cfg.data[PIX_W-1:0];
                default:          ;
            endcase
        end
    end

    // A size of zero counts as one and anything beyond the build limit as the limit.
    always_comb
    begin
        if (frame_width_reg == '0)
            eff_width = POS_W'(1);
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
            eff_width = POS_W'(MAX_WIDTH);
        else
            eff_width = frame_width_reg;

        if (frame_height_reg == '0)
            eff_height = POS_W'(1);
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
            eff_height = POS_W'(MAX_HEIGHT);
        else
            eff_height = frame_height_reg;
    end

    // The column register holds the position of the last pixel taken, so the
    // incoming pixel's position is worked out first.
    always_comb
    begin
        if (column_reg < eff_width)
        begin
            column_next = column_reg + POS_W'(1);
            row_next    = row_reg;
        end
        else
        begin
            column_next = POS_W'(1);
            row_next    = (row_reg < eff_height) ? row_reg + POS_W'(1) : POS_W'(1);
        end

        hit = (pixel.red_value == match_value_reg);
        if (hit)
        begin
            count_next      = count_reg + AREA_W'(1);
            column_sum_next = column_sum_reg + SUM_W'(column_next);
            row_sum_next    = row_sum_reg + SUM_W'(row_next);
        end
        else
        begin
            count_next      = count_reg;
            column_sum_next = column_sum_reg;
            row_sum_next    = row_sum_reg;
        end

        frame_end = (column_next >= eff_width) && (row_next >= eff_height);
    end

    assign pixel.ready = sums_ready;
    assign accept      = pixel.valid && sums_ready;
    assign sums_valid  = accept && frame_end;

    assign sums.column_sum  = column_sum_next;
    assign sums.row_sum     = row_sum_next;
    assign sums.match_count = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg     <= '0;
            row_reg        <= POS_W'(1);
            column_sum_reg <= '0;
            row_sum_reg    <= '0;
            count_reg      <= '0;
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                column_reg     <= '0;
                row_reg        <= POS_W'(1);
                column_sum_reg <= '0;
                row_sum_reg    <= '0;
                count_reg      <= '0;
            end
            else
            begin
                column_reg     <= column_next;
                row_reg        <= row_next;
                column_sum_reg <= column_sum_next;
                row_sum_reg    <= row_sum_next;
                count_reg      <= count_next;
            end
        end
    end

endmodule

// ----- design/mc_fifo.sv -----
// Short queue of finished frame sums between the front end and the divider.
// Depends on mc_pkg.
module mc_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  mc_pkg::frame_sums_t push_data,
    input  logic                push,
    output logic                not_full,
    output mc_pkg::frame_sums_t head_data,
    output logic                not_empty,
    input  logic                pop
);
    import mc_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    frame_sums_t       entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  fill_reg;

    assign not_full  = (fill_reg != CNT_W'(FIFO_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                fill_reg <= fill_reg + CNT_W'(1);
            else if (pop && !push)
                fill_reg <= fill_reg - CNT_W'(1);
        end
    end

endmodule

// ----- design/mc_divider.sv -----
// Back end of the mask centroid block: two restoring datapaths on a shared divisor
// that form both centroid coordinates one quotient bit per cycle, and the result
// register. Depends on mc_pkg and mc_if.
module mc_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  mc_pkg::frame_sums_t head_data,
    input  logic                head_valid,
    output logic                pop,
    mc_result_if.source         result
);
    import mc_pkg::*;

    div_state_t        state_reg, state_next;
    logic [SUM_W-1:0]  qx_reg, qy_reg;
    logic [AREA_W-1:0] rx_reg, ry_reg;
    logic [AREA_W-1:0] divisor_reg;
    logic [STEP_W-1:0] step_reg;
    logic [AREA_W+SUM_W-1:0] x_step, y_step;
    logic              load;
    logic              run;
    logic              deliver;
    logic              out_free;
    logic              out_valid_reg;
    logic [POS_W-1:0]  out_x_reg, out_y_reg;
    logic [AREA_W-1:0] out_area_reg;
    logic              out_empty_reg;
    logic              is_empty;

    // One restoring step: bring down the next dividend bit and subtract if it fits.
    function automatic logic [AREA_W+SUM_W-1:0] div_step(
        input logic [AREA_W-1:0] rem,
        input logic [SUM_W-1:0]  quo,
        input logic [AREA_W-1:0] divisor
    );
        logic [AREA_W:0] trial;
        logic [AREA_W:0] diff;
        trial = {rem, quo[SUM_W-1]};
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor})
            return {diff[AREA_W-1:0], quo[SUM_W-2:0], 1'b1};
        else
            return {trial[AREA_W-1:0], quo[SUM_W-2:0], 1'b0};
    endfunction

    assign out_free = !out_valid_reg || result.ready;
    assign is_empty = (divisor_reg == '0);
    assign x_step   = div_step(rx_reg, qx_reg, divisor_reg);
    assign y_step   = div_step(ry_reg, qy_reg, divisor_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (head_valid)
                    state_next = DIV_RUN;
            end
            DIV_RUN:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = DIV_HOLD;
            end
            DIV_HOLD:
            begin
                if (out_free)
                    state_next = DIV_IDLE;
            end
            default: state_next = DIV_IDLE;
        endcase
    end

    always_comb
    begin
        load    = 1'b0;
        run     = 1'b0;
        deliver = 1'b0;
        unique case (state_reg)
            DIV_IDLE: load    = head_valid;
            DIV_RUN:  run     = 1'b1;
            DIV_HOLD: deliver = out_free;
            default:  ;
        endcase
    end

    assign pop = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= DIV_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
                step_reg <= '0;
            else if (run)
                step_reg <= step_reg + STEP_W'(1);
            if (deliver)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            qx_reg      <= head_data.column_sum;
            qy_reg      <= head_data.row_sum;
            rx_reg      <= '0;
            ry_reg      <= '0;
            divisor_reg <= head_data.match_count;
        end
        else if (run)
        begin
            {rx_reg, qx_reg} <= x_step;
            {ry_reg, qy_reg} <= y_step;
        end
    end

    // An empty frame skips nothing in the divider; its quotients are simply dropped.
    always_ff @(posedge clk)
    begin
        if (deliver)
        begin
            out_x_reg     <= is_empty ? '0 : qx_reg[POS_W-1:0];
            out_y_reg     <= is_empty ? '0 : qy_reg[POS_W-1:0];
            out_area_reg  <= divisor_reg;
            out_empty_reg <= is_empty;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.centroid_x  = out_x_reg;
    assign result.centroid_y  = out_y_reg;
    assign result.object_area = out_area_reg;
    assign result.empty_frame = out_empty_reg;

endmodule

// ----- design/mask_centroid.sv -----
// Top level of the mask centroid block: front end, frame queue and divider.
// Depends on mc_pkg, mc_if, mc_front, mc_fifo and mc_divider.
//
// The block takes one red pixel value per beat in raster order and, for each
// frame, gives one result beat with the truncated mean column and row
// (1-based) of the pixels equal to match_value, their count and an empty
// flag; an empty frame reports a zero centroid. Pixels are taken at one per
// clock while the queue has room. Each frame's sums pass through a two-entry
// queue to a restoring divider (one datapath per coordinate, sharing divisor
// and step counter) that produces one quotient bit of both coordinates per
// cycle. A frame passes through the divider as load (popping the queue), 31
// steps, and hand-over to the output register, which waits for a free output.
// Small frames can fill the queue; pixel ready is then held low until the
// divider loads the next frame. Configuration writes are always taken and
// should be made between frames.
module mask_centroid #(
    parameter int MAX_WIDTH  = mc_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = mc_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    mc_cfg_if.sink      cfg,
    mc_pixel_if.sink    pixel,
    mc_result_if.source result
);
    import mc_pkg::*;

    frame_sums_t push_data;
    frame_sums_t head_data;
    logic        push;
    logic        not_full;
    logic        not_empty;
    logic        pop;

    mc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .pixel      (pixel),
        .sums       (push_data),
        .sums_valid (push),
        .sums_ready (not_full)
    );

    mc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_data (push_data),
        .push      (push),
        .not_full  (not_full),
        .head_data (head_data),
        .not_empty (not_empty),
        .pop       (pop)
    );

    mc_divider u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_data  (head_data),
        .head_valid (not_empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

// ----- design/mc_checker.sv -----
// Port-level checks for the mask centroid block, bound to the top level.
// Depends on mc_pkg.
module mc_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [mc_pkg::POS_W-1:0]  centroid_x,
    input logic [mc_pkg::POS_W-1:0]  centroid_y,
    input logic [mc_pkg::AREA_W-1:0] object_area,
    input logic                      empty_frame
);
    import mc_pkg::*;

    // A result beat that is not taken stays offered.
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat withdrawn before it was taken");

    // A stalled result beat keeps its payload.
    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(centroid_x) && $stable(centroid_y)
                                    && $stable(object_area) && $stable(empty_frame))
        else $error("result payload changed while stalled");

    // The empty flag goes with a zero area and a zero centroid.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_frame |-> centroid_x == '0 && centroid_y == '0
                                     && object_area == '0)
        else $error("empty frame reported with non-zero fields");

    // A frame with matching pixels has a non-zero area and a non-zero 1-based centroid.
    a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !empty_frame |-> object_area != '0 && centroid_x != '0
                                      && centroid_y != '0)
        else $error("non-empty frame reported with zero area or centroid");

endmodule

bind mask_centroid mc_checker u_mc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .centroid_x  (result.centroid_x),
    .centroid_y  (result.centroid_y),
    .object_area (result.object_area),
    .empty_frame (result.empty_frame)
);
